### sv/sfh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfh_pkg: shared constants, types and mixing functions of the flow hash
// Holds the hash constants, the payload types that pass between pipeline
// segments and the small functions of the hash rounds.
// ----------------------------------------------------------------------------
package sfh_pkg;

	// Hash constants of the 32-bit x86 variant.
	localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
	localparam logic [31:0] MM_C2 = 32'h1b873593;
	localparam logic [31:0] MM_N  = 32'he6546b64;
	localparam logic [31:0] MM_F1 = 32'h85ebca6b;
	localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

	// Total key length in bytes, folded in before the final mix.
	localparam logic [31:0] HASH_LEN = 32'd16;

	// Field widths and the input beat layout.
	localparam int ADDR_W  = 32;
	localparam int PORT_W  = 16;
	localparam int PROTO_W = 8;
	localparam int IN_W    = 104;
	localparam int OUT_W   = 32;

	// Canonical tuple: both addresses, packed ports and the protocol.
	typedef struct packed {
		logic [31:0]        addr_lo;
		logic [31:0]        addr_hi;
		logic [31:0]        ports;
		logic [PROTO_W-1:0] proto;
	} canon_t;

	// Four scrambled key blocks.
	typedef struct packed {
		logic [31:0] k0;
		logic [31:0] k1;
		logic [31:0] k2;
		logic [31:0] k3;
	} blocks_t;

	// Fixed rotations used by the rounds.
	function automatic logic [31:0] rotl15(input logic [31:0] v);
		rotl15 = {v[16:0], v[31:17]};
	endfunction

	function automatic logic [31:0] rotl13(input logic [31:0] v);
		rotl13 = {v[18:0], v[31:19]};
	endfunction

	// One body round: fold a scrambled block into the running hash.
	// The times-five is a shift and an add.
	function automatic logic [31:0] body_round(input logic [31:0] h,
			input logic [31:0] k);
		logic [31:0] r;
		r = rotl13(h ^ k);
		body_round = r + {r[29:0], 2'b00} + MM_N;
	endfunction

endpackage

### sv/sfh_canon.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfh_canon: endpoint ordering stage
// Puts the endpoint with the smaller address first, or on equal addresses
// the one with the smaller or equal port, and registers the canonical tuple.
// ----------------------------------------------------------------------------
module sfh_canon (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sfh_pkg::ADDR_W-1:0]  src_addr,
	input  logic [sfh_pkg::ADDR_W-1:0]  dst_addr,
	input  logic [sfh_pkg::PORT_W-1:0]  src_port,
	input  logic [sfh_pkg::PORT_W-1:0]  dst_port,
	input  logic [sfh_pkg::PROTO_W-1:0] proto,
	output logic                        out_valid,
	input  logic                        out_ready,
	output sfh_pkg::canon_t             out_data
);

	logic            vld_s1;
	sfh_pkg::canon_t data_s1;
	logic            src_first;
	sfh_pkg::canon_t canon;

	// The stage takes a beat when it is empty or its content moves on.
	assign in_ready  = !vld_s1 || out_ready;
	assign out_valid = vld_s1;
	assign out_data  = data_s1;

	// Endpoint order and packing of the canonical words.
	always_comb begin
		if (src_addr != dst_addr) begin
			src_first = src_addr < dst_addr;
		end else begin
			src_first = src_port <= dst_port;
		end
		if (src_first) begin
			canon.addr_lo = src_addr;
			canon.addr_hi = dst_addr;
			canon.ports   = {src_port, dst_port};
		end else begin
			canon.addr_lo = dst_addr;
			canon.addr_hi = src_addr;
			canon.ports   = {dst_port, src_port};
		end
		canon.proto = proto;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= canon;
		end
	end

endmodule

### sv/sfh_kmix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfh_kmix: key block scrambling
// Scrambles the four key blocks side by side in two stages: multiply by the
// first constant, then rotate and multiply by the second constant.
// ----------------------------------------------------------------------------
module sfh_kmix (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sfh_pkg::canon_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output sfh_pkg::blocks_t out_data
);

	logic             vld_s2;
	logic             vld_s3;
	logic             rdy_s3;
	sfh_pkg::blocks_t data_s2;
	sfh_pkg::blocks_t data_s3;

	assign rdy_s3    = !vld_s3 || out_ready;
	assign in_ready  = !vld_s2 || rdy_s3;
	assign out_valid = vld_s3;
	assign out_data  = data_s3;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s2 <= in_valid;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	// First multiply of each block.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2.k0 <= in_data.addr_lo * sfh_pkg::MM_C1;
			data_s2.k1 <= in_data.addr_hi * sfh_pkg::MM_C1;
			data_s2.k2 <= in_data.ports * sfh_pkg::MM_C1;
			data_s2.k3 <= {24'd0, in_data.proto} * sfh_pkg::MM_C1;
		end
	end

	// Rotate and second multiply of each block.
	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			data_s3.k0 <= sfh_pkg::rotl15(data_s2.k0) * sfh_pkg::MM_C2;
			data_s3.k1 <= sfh_pkg::rotl15(data_s2.k1) * sfh_pkg::MM_C2;
			data_s3.k2 <= sfh_pkg::rotl15(data_s2.k2) * sfh_pkg::MM_C2;
			data_s3.k3 <= sfh_pkg::rotl15(data_s2.k3) * sfh_pkg::MM_C2;
		end
	end

endmodule

### sv/sfh_body.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfh_body: hash body rounds
// Folds the scrambled blocks into the running hash, two rounds per stage,
// then xors in the key length and applies the first shift-xor of the final mix.
// ----------------------------------------------------------------------------
module sfh_body (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [31:0]      seed,
	input  logic             in_valid,
	output logic             in_ready,
	input  sfh_pkg::blocks_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      out_hash
);

	logic        vld_s4;
	logic        vld_s5;
	logic        rdy_s5;
	logic [31:0] h_s4;
	logic [31:0] k2_s4;
	logic [31:0] k3_s4;
	logic [31:0] h_s5;
	logic [31:0] h_tail;

	assign rdy_s5    = !vld_s5 || out_ready;
	assign in_ready  = !vld_s4 || rdy_s5;
	assign out_valid = vld_s5;
	assign out_hash  = h_s5;

	// Last two rounds, key length and the first shift-xor.
	always_comb begin
		h_tail = sfh_pkg::body_round(sfh_pkg::body_round(h_s4, k2_s4), k3_s4);
		h_tail = h_tail ^ sfh_pkg::HASH_LEN;
		h_tail = h_tail ^ {16'd0, h_tail[31:16]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s4 <= in_valid;
			end
			if (rdy_s5) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	// First two rounds from the seed.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			h_s4  <= sfh_pkg::body_round(sfh_pkg::body_round(seed, in_data.k0),
				in_data.k1);
			k2_s4 <= in_data.k2;
			k3_s4 <= in_data.k3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && vld_s4) begin
			h_s5 <= h_tail;
		end
	end

endmodule

### sv/sfh_fmix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfh_fmix: final avalanche mix
// Multiplies, shift-xors, multiplies and shift-xors in three stages; the
// last stage register is the output register of the block.
// ----------------------------------------------------------------------------
module sfh_fmix (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] in_hash,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_hash
);

	logic        vld_s6;
	logic        vld_s7;
	logic        vld_s8;
	logic        rdy_s7;
	logic        rdy_s8;
	logic [31:0] h_s6;
	logic [31:0] h_s7;
	logic [31:0] h_s8;
	logic [31:0] x6;

	assign rdy_s8    = !vld_s8 || out_ready;
	assign rdy_s7    = !vld_s7 || rdy_s8;
	assign in_ready  = !vld_s6 || rdy_s7;
	assign out_valid = vld_s8;
	assign out_hash  = h_s8;

	assign x6 = h_s6 ^ {13'd0, h_s6[31:13]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s6 <= in_valid;
			end
			if (rdy_s7) begin
				vld_s7 <= vld_s6;
			end
			if (rdy_s8) begin
				vld_s8 <= vld_s7;
			end
		end
	end

	// Multiply, shift-xor and multiply, shift-xor.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			h_s6 <= in_hash * sfh_pkg::MM_F1;
		end
		if (rdy_s7 && vld_s6) begin
			h_s7 <= x6 * sfh_pkg::MM_F2;
		end
		if (rdy_s8 && vld_s7) begin
			h_s8 <= h_s7 ^ {16'd0, h_s7[31:16]};
		end
	end

endmodule

### sv/symmetric_flow_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_flow_hash: direction-independent five-tuple flow hash
// Orders the two endpoints canonically and hashes the four resulting words
// with the 32-bit x86 murmur hash under a programmable seed.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Width  Content
// s_axis    in         104    one five-tuple per beat
// m_axis    out        32     one flow hash per beat
// cfg       in         32     hash seed write
//
// One tuple enters per clock while m_axis does not stall; each result passes
// through eight register stages (ordering, two key scramble stages,
// two body stages of two rounds each, three final mix stages).
// Each stage moves on when it is empty or the next one moves, so a stall on
// m_axis fills the bubbles and then holds s_axis; nothing is lost or repeated.
// Reset clears the stage valid bits and sets the seed to zero.
// ----------------------------------------------------------------------------
module symmetric_flow_hash (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [31:0]                 cfg_wr_data,   // hash_seed
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// source_address, destination_address, source_port, destination_port,
	// protocol_number
	input  logic [sfh_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [sfh_pkg::OUT_W-1:0]   m_axis_tdata   // flow_hash
);

	logic [31:0]      seed_q;
	logic             canon_valid;
	logic             canon_ready;
	sfh_pkg::canon_t  canon_data;
	logic             blk_valid;
	logic             blk_ready;
	sfh_pkg::blocks_t blk_data;
	logic             body_valid;
	logic             body_ready;
	logic [31:0]      body_hash;

	// Seed register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_wr_en) begin
			seed_q <= cfg_wr_data;
		end
	end

	sfh_canon u_canon (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.src_addr  (s_axis_tdata[31:0]),
		.dst_addr  (s_axis_tdata[63:32]),
		.src_port  (s_axis_tdata[79:64]),
		.dst_port  (s_axis_tdata[95:80]),
		.proto     (s_axis_tdata[103:96]),
		.out_valid (canon_valid),
		.out_ready (canon_ready),
		.out_data  (canon_data)
	);

	sfh_kmix u_kmix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (canon_valid),
		.in_ready  (canon_ready),
		.in_data   (canon_data),
		.out_valid (blk_valid),
		.out_ready (blk_ready),
		.out_data  (blk_data)
	);

	sfh_body u_body (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed      (seed_q),
		.in_valid  (blk_valid),
		.in_ready  (blk_ready),
		.in_data   (blk_data),
		.out_valid (body_valid),
		.out_ready (body_ready),
		.out_hash  (body_hash)
	);

	sfh_fmix u_fmix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (body_valid),
		.in_ready  (body_ready),
		.in_hash   (body_hash),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_hash  (m_axis_tdata)
	);

endmodule
